@@ src/fpse_pkg.sv @@
// Shared types and constants for the float to PCM sample encoder.
// No dependencies.
package fpse_pkg;

    localparam logic [5:0] DEPTH_16 = 6'd16;
    localparam logic [5:0] DEPTH_24 = 6'd24;
    localparam logic [5:0] DEPTH_32 = 6'd32;
    localparam logic [5:0] DEPTH_RESET = DEPTH_16;

    localparam logic [22:0] SCALE_16 = 23'd32767;
    localparam logic [22:0] SCALE_24 = 23'd8388607;

    localparam logic [2:0] BYTES_NONE = 3'd0;
    localparam logic [2:0] BYTES_16   = 3'd2;
    localparam logic [2:0] BYTES_32   = 3'd4;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic        last;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  byte_count;
        logic        depth_error;
        logic        last_out;
    } t_out_beat;

endpackage

@@ src/float_to_pcm_sample_encoder.sv @@
// Float to PCM sample encoder: clamp, scale, round to single, truncate (depth 32 passes the float bits as is).
// Depends on fpse_pkg.
// Each input beat is held in the input reg, then in the result reg.
// Throughput: one beat per cycle; stalls propagate back through both regs.
// The scale multiply (24x23) and rounding shift sit between the two regs.
// Reset (synchronous, active low) empties both stages and sets depth to 16.
module float_to_pcm_sample_encoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  fpse_pkg::t_in_beat  i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output fpse_pkg::t_out_beat o_out_beat,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_data
);

    logic [5:0]          r_depth;
    logic                r_in_vld;
    fpse_pkg::t_in_beat  r_in;
    logic                r_out_vld;
    fpse_pkg::t_out_beat r_out;
    fpse_pkg::t_out_beat n_out;
    logic                adv_out;

    logic        sgn;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic        is_nan, is_sat, is_24;
    logic [23:0] mant;
    logic [22:0] scale;
    logic [47:0] prod;
    logic [4:0]  k;
    logic [47:0] kept, rnd, low_mask;
    logic        guard, sticky, lsb;
    logic [7:0]  sh;
    logic [47:0] shifted;
    logic [22:0] mag;
    logic [31:0] sval;

    assign adv_out    = !(r_out_vld && i_out_stall);
    assign o_in_stall = r_in_vld && !adv_out;

    always_comb begin
        sgn    = r_in.sample_bits[31];
        expo   = r_in.sample_bits[30:23];
        frac   = r_in.sample_bits[22:0];
        is_nan = (expo == 8'hFF) && (frac != 23'd0);
        is_sat = is_nan || (expo > 8'd127) || ((expo == 8'd127) && (frac != 23'd0));
        is_24  = (r_depth == fpse_pkg::DEPTH_24);
        scale  = is_24 ? fpse_pkg::SCALE_24 : fpse_pkg::SCALE_16;
        mant   = {1'b1, frac};
        prod   = {24'd0, mant} * {25'd0, scale};
        if (is_24) begin
            k = prod[46] ? 5'd23 : 5'd22;
        end else begin
            k = prod[38] ? 5'd15 : 5'd14;
        end
        kept     = prod >> k;
        low_mask = (48'd1 << (k - 5'd1)) - 48'd1;
        guard    = prod[k - 5'd1];
        sticky   = |(prod & low_mask);
        lsb      = kept[0];
        rnd      = (kept + {47'd0, guard && (sticky || lsb)}) << k;
        sh       = 8'd150 - expo;
        shifted  = (sh > 8'd47) ? 48'd0 : (rnd >> sh[5:0]);
        if (expo == 8'd0) begin
            mag = 23'd0;
        end else if (is_sat) begin
            mag = scale;
        end else begin
            mag = shifted[22:0];
        end
        sval = (sgn && !is_nan) ? (32'd0 - {9'd0, mag}) : {9'd0, mag};

        n_out.last_out    = r_in.last;
        n_out.word        = 32'd0;
        n_out.byte_count  = fpse_pkg::BYTES_NONE;
        n_out.depth_error = 1'b0;
        case (r_depth)
            fpse_pkg::DEPTH_16: begin
                n_out.word       = {16'd0, sval[15:0]};
                n_out.byte_count = fpse_pkg::BYTES_16;
            end
            fpse_pkg::DEPTH_24: begin
                n_out.word       = sval;
                n_out.byte_count = fpse_pkg::BYTES_32;
            end
            fpse_pkg::DEPTH_32: begin
                n_out.word       = r_in.sample_bits;
                n_out.byte_count = fpse_pkg::BYTES_32;
            end
            default: begin
                n_out.depth_error = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= fpse_pkg::DEPTH_RESET;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_depth <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (adv_out) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_beat;
        end
        if (adv_out && r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.depth_error
        |-> o_out_beat.word == 32'd0 && o_out_beat.byte_count == fpse_pkg::BYTES_NONE)
        else $error("error beat carries data");

    a_w16_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.byte_count == fpse_pkg::BYTES_16
        |-> o_out_beat.word[31:16] == 16'd0)
        else $error("16-bit beat has upper bits set");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld && r_out_vld)
        else $error("input stalled with a free stage");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !o_in_stall |=> o_out_valid)
        else $error("beat lost between stages");

endmodule
